/* rtl/isl_pkg.sv */
// ----------------------------------------------------------------------------
// isl_pkg: shared types and constants of the indexed shift list
// Request modes, result status codes, cell commands and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package isl_pkg;

  // Default number of cells in the chain
  localparam int MAX_ENTRIES_DEF = 64;

  // Field widths of the request and result items
  localparam int MODE_W   = 4;
  localparam int INDEX_W  = 7;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;
  localparam int CAP_W    = 7;

  // Capacity register after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Word returned by a read outside the list
  localparam logic signed [WORD_W-1:0] BAD_READ = -32'sd1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_AT       = 4'd0,
    MODE_ADD_FIRST    = 4'd1,
    MODE_ADD_LAST     = 4'd2,
    MODE_REMOVE_AT    = 4'd3,
    MODE_REMOVE_FIRST = 4'd4,
    MODE_REMOVE_LAST  = 4'd5,
    MODE_GET_AT       = 4'd6,
    MODE_GET_FIRST    = 4'd7,
    MODE_GET_LAST     = 4'd8,
    MODE_CLEAR        = 4'd9
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_READ   = 2'd3
  } cell_op_t;

endpackage

`default_nettype wire

/* rtl/isl_if.sv */
// ----------------------------------------------------------------------------
// isl_req_if / isl_rsp_if: request and result channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface isl_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [isl_pkg::MODE_W-1:0]           mode;
  logic [isl_pkg::INDEX_W-1:0]          index;
  logic signed [isl_pkg::WORD_W-1:0]    value;

  modport source (output valid, output mode, output index, output value, input ready);
  modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

interface isl_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [isl_pkg::STATUS_W-1:0]         status;
  logic signed [isl_pkg::WORD_W-1:0]    read_value;
  logic [isl_pkg::COUNT_W-1:0]          count;
  logic                                 is_full;
  logic                                 is_empty;

  modport source (output valid, output status, output read_value, output count,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input status, input read_value, input count,
                  input is_full, input is_empty, output ready);
endinterface

`default_nettype wire

/* rtl/isl_cell.sv */
// ----------------------------------------------------------------------------
// isl_cell: one list entry of the shift chain
// Holds one word, loads the new word or a neighbor's word, and drives the
// read bus when it is the addressed position.
// ----------------------------------------------------------------------------
`default_nettype none

module isl_cell #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  wire                                 clk,
  input  isl_pkg::cell_op_t                   op,
  input  wire [PW-1:0]                        pos,
  input  wire [PW-1:0]                        cnt,
  input  wire signed [isl_pkg::WORD_W-1:0]    word,
  input  wire signed [isl_pkg::WORD_W-1:0]    left,
  input  wire signed [isl_pkg::WORD_W-1:0]    right,
  output logic signed [isl_pkg::WORD_W-1:0]   entry,
  output logic signed [isl_pkg::WORD_W-1:0]   rd
);

  localparam logic [PW-1:0] MY_POS  = PW'(IDX);
  localparam logic [PW-1:0] MY_NEXT = PW'(IDX + 1);

  // Load new word, take left neighbor on insert, right neighbor on remove
  always_ff @(posedge clk) begin
    case (op)
      isl_pkg::CELL_INSERT: begin
        if (pos == MY_POS) begin
          entry <= word;
        end else if (MY_POS > pos && MY_POS <= cnt) begin
          entry <= left;
        end
      end
      isl_pkg::CELL_REMOVE: begin
        if (MY_POS >= pos && MY_NEXT < cnt) begin
          entry <= right;
        end
      end
      default: begin
      end
    endcase
  end

  // Drive the read bus only when addressed
  assign rd = (op == isl_pkg::CELL_READ && pos == MY_POS) ? entry : '0;

endmodule

`default_nettype wire

/* rtl/isl_chain.sv */
// ----------------------------------------------------------------------------
// isl_chain: row of list cells with neighbor links and a read bus
// Every cell sees the same command; words move by one cell on each accepted insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module isl_chain #(
  parameter int N  = isl_pkg::MAX_ENTRIES_DEF,
  parameter int PW = 7
) (
  input  wire                                 clk,
  input  isl_pkg::cell_op_t                   op,
  input  wire [PW-1:0]                        pos,
  input  wire [PW-1:0]                        cnt,
  input  wire signed [isl_pkg::WORD_W-1:0]    word,
  output logic signed [isl_pkg::WORD_W-1:0]   rd
);

  logic signed [isl_pkg::WORD_W-1:0] entry [N];
  logic signed [isl_pkg::WORD_W-1:0] cell_rd [N];

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic signed [isl_pkg::WORD_W-1:0] left;
    logic signed [isl_pkg::WORD_W-1:0] right;

    // Tie the open ends of the chain
    if (k == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = entry[k-1];
    end
    if (k == N-1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = entry[k+1];
    end

    isl_cell #(.IDX(k), .PW(PW)) u_cell (
      .clk   (clk),
      .op    (op),
      .pos   (pos),
      .cnt   (cnt),
      .word  (word),
      .left  (left),
      .right (right),
      .entry (entry[k]),
      .rd    (cell_rd[k])
    );
  end

  // Collect the read bus; at most one cell drives it
  always_comb begin
    rd = '0;
    for (int k = 0; k < N; k++) begin
      rd = rd | cell_rd[k];
    end
  end

endmodule

`default_nettype wire

/* rtl/indexed_shift_list_core.sv */
// ----------------------------------------------------------------------------
// indexed_shift_list_core: bounded ordered list with insert/remove at index
// Decodes each request, checks bounds and fullness, drives the cell chain
// and registers one result item per request.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    mode, index, value
//  rsp      out  valid/ready    status, read_value, count, is_full, is_empty
//  cfg      in   cfg_we         cfg_wdata (capacity)
//
//  One item per cycle while the result side takes its items: a request is checked and applied
//  to the cell chain in the cycle it is accepted; the chain moves every word one cell in parallel.
//  The result is in the output register in the cycle after acceptance.
//  req.ready is high while the output register is empty or being taken.
//  Reset empties the list and sets capacity to 64; cell words are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_shift_list_core #(
  parameter int MAX_ENTRIES = isl_pkg::MAX_ENTRIES_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire [isl_pkg::CAP_W-1:0]     cfg_wdata,
  isl_req_if.sink                      req,
  isl_rsp_if.source                    rsp
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > isl_pkg::INDEX_W) ? CW : isl_pkg::INDEX_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_ENTRIES);

  logic [isl_pkg::CAP_W-1:0] capacity;
  logic [CW-1:0]             cnt;

  logic                      accept;
  logic [XW-1:0]             cnt_x;
  logic [XW-1:0]             idx_x;
  logic [XW-1:0]             cap_x;
  logic [XW-1:0]             cap_eff;
  logic                      full_now;
  logic [XW-1:0]             pos;
  logic [XW-1:0]             cnt_next;
  isl_pkg::cell_op_t         op;
  isl_pkg::cell_op_t         chain_op;
  isl_pkg::status_t          st;
  logic signed [isl_pkg::WORD_W-1:0] rd;
  logic signed [isl_pkg::WORD_W-1:0] chain_rd;

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Decode the request against the current size and capacity
  always_comb begin
    cnt_x    = XW'(cnt);
    idx_x    = XW'(req.index);
    cap_x    = XW'(capacity);
    if (capacity == '0) begin
      cap_eff = XW'(1);
    end else if (cap_x > MAX_X) begin
      cap_eff = MAX_X;
    end else begin
      cap_eff = cap_x;
    end
    full_now = cnt_x >= cap_eff;
    op       = isl_pkg::CELL_HOLD;
    pos      = '0;
    st       = isl_pkg::ST_BAD_INDEX;
    rd       = '0;
    cnt_next = cnt_x;
    case (isl_pkg::mode_t'(req.mode))
      isl_pkg::MODE_ADD_AT, isl_pkg::MODE_ADD_FIRST, isl_pkg::MODE_ADD_LAST: begin
        if (req.mode == isl_pkg::MODE_ADD_AT) begin
          pos = idx_x;
        end else if (req.mode == isl_pkg::MODE_ADD_LAST) begin
          pos = cnt_x;
        end
        if (pos > cnt_x) begin
          st = isl_pkg::ST_BAD_INDEX;
        end else if (full_now) begin
          st = isl_pkg::ST_FULL;
        end else begin
          st       = isl_pkg::ST_OK;
          op       = isl_pkg::CELL_INSERT;
          cnt_next = cnt_x + XW'(1);
        end
      end
      isl_pkg::MODE_REMOVE_AT, isl_pkg::MODE_REMOVE_FIRST,
      isl_pkg::MODE_REMOVE_LAST: begin
        if (req.mode == isl_pkg::MODE_REMOVE_AT) begin
          pos = idx_x;
        end else if (req.mode == isl_pkg::MODE_REMOVE_LAST) begin
          pos = cnt_x - XW'(1);
        end
        if (cnt_x == '0) begin
          st = isl_pkg::ST_EMPTY;
        end else if (pos >= cnt_x) begin
          st = isl_pkg::ST_BAD_INDEX;
        end else begin
          st       = isl_pkg::ST_OK;
          op       = isl_pkg::CELL_REMOVE;
          cnt_next = cnt_x - XW'(1);
        end
      end
      isl_pkg::MODE_GET_AT, isl_pkg::MODE_GET_FIRST, isl_pkg::MODE_GET_LAST: begin
        if (req.mode == isl_pkg::MODE_GET_AT) begin
          pos = idx_x;
        end else if (req.mode == isl_pkg::MODE_GET_LAST) begin
          pos = cnt_x - XW'(1);
        end
        if (cnt_x == '0 || pos >= cnt_x) begin
          st = isl_pkg::ST_BAD_INDEX;
          rd = isl_pkg::BAD_READ;
        end else begin
          st = isl_pkg::ST_OK;
          op = isl_pkg::CELL_READ;
          rd = chain_rd;
        end
      end
      isl_pkg::MODE_CLEAR: begin
        st       = isl_pkg::ST_OK;
        cnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  // Act on the chain only for an accepted item
  assign chain_op = accept ? op : isl_pkg::CELL_HOLD;

  isl_chain #(.N(MAX_ENTRIES), .PW(XW)) u_chain (
    .clk  (clk),
    .op   (chain_op),
    .pos  (pos),
    .cnt  (cnt_x),
    .word (req.value),
    .rd   (chain_rd)
  );

  // Hold capacity, size and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= isl_pkg::CAP_RESET;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        cnt       <= CW'(cnt_next);
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status     <= st;
      rsp.read_value <= rd;
      rsp.count      <= isl_pkg::COUNT_W'(cnt_next);
      rsp.is_full    <= cnt_next >= cap_eff;
      rsp.is_empty   <= cnt_next == '0;
    end
  end

endmodule

`default_nettype wire

/* sim/indexed_shift_list_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_shift_list_core_tb: self-checking bench for the indexed shift list
// Drives insert, remove, read and clear requests through the valid/ready
// channels and tracks the list contents, size and capacity in the bench. Each
// result is checked field by field against the oldest expected result. The
// run covers directed edge cases, capacity changes with the list idle, a long
// output hold-off, and random traffic with random idling on both sides.
// ----------------------------------------------------------------------------

module indexed_shift_list_core_tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [isl_pkg::MODE_W-1:0] FIRST_UNUSED_MODE = 4'd10;
  localparam logic [isl_pkg::MODE_W-1:0] LAST_UNUSED_MODE  = 4'd15;
  localparam logic signed [isl_pkg::WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [isl_pkg::WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    isl_pkg::status_t                    status;
    logic signed [isl_pkg::WORD_W-1:0]   read_value;
    logic [isl_pkg::COUNT_W-1:0]         count;
    logic                                is_full;
    logic                                is_empty;
  } list_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [isl_pkg::CAP_W-1:0] cfg_wdata;

  isl_req_if req_ch ();
  isl_rsp_if rsp_ch ();

  indexed_shift_list_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Bench copy of the list
  logic signed [isl_pkg::WORD_W-1:0] list_words [isl_pkg::MAX_ENTRIES_DEF];
  int                                list_len = 0;
  logic [isl_pkg::CAP_W-1:0]         list_cap = isl_pkg::CAP_RESET;

  list_result_t pending_results[$];
  int           mismatches  = 0;
  int           cycle_count = 0;
  bit           sender_idling   = 1'b1;
  bit           receiver_idling = 1'b1;
  int           hold_off_len    = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Clamp the capacity register to the range the list can hold
  function automatic int cap_limit();
    if (list_cap == 0) return 1;
    if (list_cap > isl_pkg::MAX_ENTRIES_DEF) return isl_pkg::MAX_ENTRIES_DEF;
    return int'(list_cap);
  endfunction

  // Apply one request to the bench list and return the result it must give
  function automatic list_result_t apply_request(logic [isl_pkg::MODE_W-1:0] m,
                                                 logic [isl_pkg::INDEX_W-1:0] idx,
                                                 logic signed [isl_pkg::WORD_W-1:0] v);
    list_result_t r;
    int pos;
    r.status     = isl_pkg::ST_OK;
    r.read_value = '0;
    case (m)
      isl_pkg::MODE_ADD_AT, isl_pkg::MODE_ADD_FIRST, isl_pkg::MODE_ADD_LAST: begin
        pos = (m == isl_pkg::MODE_ADD_AT) ? int'(idx) :
              (m == isl_pkg::MODE_ADD_FIRST) ? 0 : list_len;
        if (pos > list_len) begin
          r.status = isl_pkg::ST_BAD_INDEX;
        end else if (list_len >= cap_limit()) begin
          r.status = isl_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = v;
          list_len++;
        end
      end
      isl_pkg::MODE_REMOVE_AT, isl_pkg::MODE_REMOVE_FIRST,
      isl_pkg::MODE_REMOVE_LAST: begin
        pos = (m == isl_pkg::MODE_REMOVE_AT) ? int'(idx) :
              (m == isl_pkg::MODE_REMOVE_FIRST) ? 0 : list_len - 1;
        if (list_len == 0) begin
          r.status = isl_pkg::ST_EMPTY;
        end else if (pos >= list_len) begin
          r.status = isl_pkg::ST_BAD_INDEX;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      isl_pkg::MODE_GET_AT, isl_pkg::MODE_GET_FIRST, isl_pkg::MODE_GET_LAST: begin
        pos = (m == isl_pkg::MODE_GET_AT) ? int'(idx) :
              (m == isl_pkg::MODE_GET_FIRST) ? 0 : list_len - 1;
        if (list_len == 0 || pos >= list_len) begin
          r.status     = isl_pkg::ST_BAD_INDEX;
          r.read_value = isl_pkg::BAD_READ;
        end else begin
          r.read_value = list_words[pos];
        end
      end
      isl_pkg::MODE_CLEAR: begin
        list_len = 0;
      end
      default: begin
        r.status = isl_pkg::ST_BAD_INDEX;
      end
    endcase
    r.count    = isl_pkg::COUNT_W'(list_len);
    r.is_full  = (list_len >= cap_limit());
    r.is_empty = (list_len == 0);
    return r;
  endfunction

  // Predict a result for every accepted request
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready)
      pending_results.push_back(apply_request(req_ch.mode, req_ch.index, req_ch.value));
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Check every accepted result against the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",     32'(want.status),     32'(rsp_ch.status));
        check_field("read_value", want.read_value,      rsp_ch.read_value);
        check_field("count",      32'(want.count),      32'(rsp_ch.count));
        check_field("is_full",    32'(want.is_full),    32'(rsp_ch.is_full));
        check_field("is_empty",   32'(want.is_empty),   32'(rsp_ch.is_empty));
      end
    end
  end

  // Result side: long hold-off on request, otherwise random stall bursts
  initial begin
    int stall;
    stall = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        hold_off_len--;
        rsp_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one item and hold it until accepted; valid stays high afterwards
  task automatic send_request(logic [isl_pkg::MODE_W-1:0] m,
                              logic [isl_pkg::INDEX_W-1:0] idx,
                              logic signed [isl_pkg::WORD_W-1:0] v);
    if (sender_idling && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= m;
    req_ch.index <= idx;
    req_ch.value <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [isl_pkg::CAP_W-1:0] cap);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
    list_cap  = cap;
  endtask

  function automatic logic signed [isl_pkg::WORD_W-1:0] random_word();
    case ($urandom_range(0, 11))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return isl_pkg::BAD_READ;
      default: return $urandom;
    endcase
  endfunction

  // Mostly in-range positions, now and then anywhere in the index field
  function automatic logic [isl_pkg::INDEX_W-1:0] random_index();
    if ($urandom_range(0, 9) == 0) return isl_pkg::INDEX_W'($urandom_range(0, 127));
    return isl_pkg::INDEX_W'($urandom_range(0, list_len + 1));
  endfunction

  task automatic send_random_request(int add_weight);
    int pick;
    logic [isl_pkg::MODE_W-1:0] m;
    pick = $urandom_range(0, 99);
    if (pick < add_weight) begin
      case ($urandom_range(0, 2))
        0:       m = isl_pkg::MODE_ADD_AT;
        1:       m = isl_pkg::MODE_ADD_FIRST;
        default: m = isl_pkg::MODE_ADD_LAST;
      endcase
    end else if (pick == 99) begin
      m = isl_pkg::MODE_CLEAR;
    end else if (pick >= 97) begin
      m = isl_pkg::MODE_W'($urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE));
    end else if (pick < add_weight + (97 - add_weight) / 2) begin
      case ($urandom_range(0, 2))
        0:       m = isl_pkg::MODE_REMOVE_AT;
        1:       m = isl_pkg::MODE_REMOVE_FIRST;
        default: m = isl_pkg::MODE_REMOVE_LAST;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       m = isl_pkg::MODE_GET_AT;
        1:       m = isl_pkg::MODE_GET_FIRST;
        default: m = isl_pkg::MODE_GET_LAST;
      endcase
    end
    send_request(m, random_index(), random_word());
  endtask

  // Reads, removes and out-of-range adds on an empty list, plus unused modes and a clear
  task automatic test_empty_list();
    send_request(isl_pkg::MODE_GET_FIRST, '0, '0);
    send_request(isl_pkg::MODE_GET_LAST, '0, '0);
    send_request(isl_pkg::MODE_GET_AT, '0, '0);
    send_request(isl_pkg::MODE_REMOVE_FIRST, '0, '0);
    send_request(isl_pkg::MODE_REMOVE_LAST, '0, '0);
    send_request(isl_pkg::MODE_REMOVE_AT, '0, '0);
    send_request(isl_pkg::MODE_ADD_AT, 7'd1, WORD_MAX);
    for (int m = FIRST_UNUSED_MODE; m <= LAST_UNUSED_MODE; m++)
      send_request(isl_pkg::MODE_W'(m), 7'h7F, isl_pkg::BAD_READ);
    send_request(isl_pkg::MODE_CLEAR, '0, '0);
  endtask

  // Insert, read and remove at the ends and in the middle with extreme words
  task automatic test_edit_ops();
    send_request(isl_pkg::MODE_ADD_FIRST, 7'h7F, WORD_MAX);
    send_request(isl_pkg::MODE_ADD_LAST, '0, WORD_MIN);
    send_request(isl_pkg::MODE_ADD_AT, 7'd1, isl_pkg::BAD_READ);
    send_request(isl_pkg::MODE_ADD_AT, 7'h7F, '0);
    send_request(isl_pkg::MODE_GET_AT, 7'd1, '0);
    send_request(isl_pkg::MODE_GET_FIRST, 7'h7F, '0);
    send_request(isl_pkg::MODE_GET_LAST, '0, '0);
    send_request(isl_pkg::MODE_GET_AT, 7'h7F, '0);
    send_request(isl_pkg::MODE_REMOVE_AT, 7'h7F, '0);
    send_request(isl_pkg::MODE_REMOVE_AT, 7'd1, '0);
    send_request(isl_pkg::MODE_REMOVE_LAST, '0, '0);
    send_request(isl_pkg::MODE_REMOVE_FIRST, '0, '0);
  endtask

  // Full checks at the smallest and clamped capacities, then shrink below size
  task automatic test_capacity_limits();
    write_capacity(7'd1);
    send_request(isl_pkg::MODE_ADD_LAST, '0, random_word());
    send_request(isl_pkg::MODE_ADD_FIRST, '0, random_word());
    send_request(isl_pkg::MODE_ADD_AT, 7'd5, random_word());
    write_capacity(7'd0);
    send_request(isl_pkg::MODE_ADD_LAST, '0, random_word());
    send_request(isl_pkg::MODE_GET_FIRST, '0, '0);
    send_request(isl_pkg::MODE_REMOVE_LAST, '0, '0);
    write_capacity(7'h7F);
    while (list_len < isl_pkg::MAX_ENTRIES_DEF)
      send_request(isl_pkg::MODE_ADD_AT, isl_pkg::INDEX_W'($urandom_range(0, list_len)),
                   random_word());
    send_request(isl_pkg::MODE_ADD_LAST, '0, random_word());
    send_request(isl_pkg::MODE_ADD_AT, 7'h7F, random_word());
    send_request(isl_pkg::MODE_GET_LAST, '0, '0);
    write_capacity(7'd5);
    send_request(isl_pkg::MODE_ADD_FIRST, '0, random_word());
    repeat (62) begin
      send_request(isl_pkg::MODE_GET_AT,
                   isl_pkg::INDEX_W'($urandom_range(0, list_len - 1)), '0);
      send_request(isl_pkg::MODE_REMOVE_AT,
                   isl_pkg::INDEX_W'($urandom_range(0, list_len - 1)), '0);
    end
    send_request(isl_pkg::MODE_ADD_LAST, '0, random_word());
    send_request(isl_pkg::MODE_CLEAR, '0, '0);
    write_capacity(isl_pkg::CAP_RESET);
  endtask

  // Hold the result side off long enough that the request side stalls
  task automatic test_backpressure();
    sender_idling = 1'b0;
    hold_off_len  = 150;
    repeat (40) send_random_request(55);
    sender_idling = 1'b1;
  endtask

  task automatic run_phase(logic [isl_pkg::CAP_W-1:0] cap, int items, int add_weight);
    write_capacity(cap);
    repeat (items) send_random_request(add_weight);
  endtask

  // Random traffic over a series of capacities, growing and shrinking
  task automatic test_random_traffic();
    run_phase(isl_pkg::CAP_RESET, 110, 55);
    run_phase(7'd3, 100, 40);
    run_phase(7'h7F, 110, 60);
    run_phase(7'd1, 70, 45);
    run_phase(7'd17, 110, 50);
    run_phase(7'd0, 50, 40);
    run_phase(7'd48, 110, 35);
  endtask

  // Back-to-back traffic with no idling on either side
  task automatic test_full_rate();
    sender_idling   = 1'b0;
    receiver_idling = 1'b0;
    run_phase(isl_pkg::CAP_RESET, 160, 50);
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= isl_pkg::CAP_RESET;
    req_ch.valid <= 1'b0;
    req_ch.mode  <= isl_pkg::MODE_ADD_AT;
    req_ch.index <= '0;
    req_ch.value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_edit_ops();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic();
    test_full_rate();

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
